FILE: rtl/ignition_power_timer_with_heartbeat_assert.svh
// Assertion macros for the ignition power timer.
`ifndef IGNITION_POWER_TIMER_WITH_HEARTBEAT_ASSERT_SVH
`define IGNITION_POWER_TIMER_WITH_HEARTBEAT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPTHB_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipthb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPTHB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipthb assertion failed");

`endif

FILE: rtl/ipthb_pkg.sv
// Package with types and constants for the ignition power timer.
`timescale 1ns / 1ps

package ipthb_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = 23;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ADC_THRESHOLD  = 3'd0,
      CSR_ON_DELAY       = 3'd1,
      CSR_OFF_DELAY      = 3'd2,
      CSR_LED_OFF_POINT  = 3'd3,
      CSR_HB_WINDOW      = 3'd4,
      CSR_HB_SAMPLE      = 3'd5,
      CSR_HB_MIN_EDGES   = 3'd6,
      CSR_RESTART_HOLD   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  adc_threshold;
      logic [15:0] on_delay;
      logic [22:0] off_delay;
      logic [22:0] led_off_point;
      logic [21:0] heartbeat_window;
      logic [5:0]  heartbeat_sample;
      logic [15:0] heartbeat_min_edges;
      logic [19:0] restart_hold;
   } config_type;

   typedef struct packed {
      logic        phase_active;
      logic [15:0] supply_timeout;
      logic [15:0] on_countdown;
      logic [22:0] off_countdown;
      logic [21:0] window_countdown;
      logic [5:0]  sample_countdown;
      logic        heartbeat_prev;
      logic        heartbeat_cur;
      logic [15:0] edge_count;
      logic [19:0] hold_countdown;
      logic        switch_reg;
      logic        led_reg;
   } state_type;

   localparam config_type ConfigReset = '{
      adc_threshold:       8'd10,
      on_delay:            16'd45000,
      off_delay:           23'd5400000,
      led_off_point:       23'd5355000,
      heartbeat_window:    22'd2160000,
      heartbeat_sample:    6'd50,
      heartbeat_min_edges: 16'd7000,
      restart_hold:        20'd108000
   };

   localparam logic [15:0] EdgeCountReset = 16'd5000;
   localparam logic [15:0] EdgeCountMax = 16'hFFFF;

   localparam state_type StateReset = '{
      phase_active:     1'b0,
      supply_timeout:   16'd0,
      on_countdown:     16'd0,
      off_countdown:    23'd0,
      window_countdown: ConfigReset.heartbeat_window,
      sample_countdown: ConfigReset.heartbeat_sample,
      heartbeat_prev:   1'b0,
      heartbeat_cur:    1'b0,
      edge_count:       EdgeCountReset,
      hold_countdown:   20'd0,
      switch_reg:       1'b0,
      led_reg:          1'b0
   };

endpackage

FILE: rtl/ignition_power_timer_with_heartbeat.sv
// Top level of the ignition power timer with heartbeat watchdog.
// The result of an accepted word is registered and shows in the cycle after it is accepted.
// Throughput: one word per cycle; the tick update is one pass of logic into the state registers.
// Input stalls only while a result waits and the output is stalled.
// Reset: synchronous, active high; state and configuration return to their defaults.
// The result register comes out of reset empty.
`timescale 1ns / 1ps
`include "ignition_power_timer_with_heartbeat_assert.svh"

module ignition_power_timer_with_heartbeat (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_ignition_in,
   input  logic [7:0]                            req_supply_sample,
   input  logic                                  req_heartbeat_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_switch_on,
   output logic                                  rsp_led_on,
   output logic                                  rsp_active,
   output logic                                  rsp_holding,
   input  logic                                  csr_write_en,
   input  logic [ipthb_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [ipthb_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import ipthb_pkg::*;

   config_type cfg_ff;
   config_type cfg_in;
   state_type  st_ff;
   state_type  st_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_switch_ff;
   logic       rsp_led_ff;
   logic       rsp_active_ff;
   logic       rsp_holding_ff;
   logic       req_accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ADC_THRESHOLD:  cfg_in.adc_threshold = csr_wdata[7:0];
            CSR_ON_DELAY:       cfg_in.on_delay = csr_wdata[15:0];
            CSR_OFF_DELAY:      cfg_in.off_delay = csr_wdata[22:0];
            CSR_LED_OFF_POINT:  cfg_in.led_off_point = csr_wdata[22:0];
            CSR_HB_WINDOW:      cfg_in.heartbeat_window = csr_wdata[21:0];
            CSR_HB_SAMPLE:      cfg_in.heartbeat_sample = csr_wdata[5:0];
            CSR_HB_MIN_EDGES:   cfg_in.heartbeat_min_edges = csr_wdata[15:0];
            CSR_RESTART_HOLD:   cfg_in.restart_hold = csr_wdata[19:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // One tick of the controller: idle gate, watchdog hold, then heartbeat and supply timing.
   always_comb begin
      st_in = st_ff;
      if (req_accept) begin
         if (!st_ff.phase_active) begin
            if ((req_supply_sample < cfg_ff.adc_threshold) || req_ignition_in) begin
               st_in.switch_reg = 1'b0;
            end else if (cfg_ff.on_delay == 16'd0) begin
               st_in.switch_reg = 1'b0;
               st_in.led_reg = 1'b0;
            end else begin
               st_in.on_countdown = cfg_ff.on_delay;
               st_in.off_countdown = cfg_ff.off_delay;
               st_in.supply_timeout = cfg_ff.on_delay;
               st_in.phase_active = 1'b1;
            end
         end else if (st_ff.hold_countdown != 20'd0) begin
            st_in.hold_countdown = st_ff.hold_countdown - 20'd1;
            if (st_in.hold_countdown == 20'd0) begin
               if (st_in.led_reg) begin
                  st_in.switch_reg = 1'b1;
               end
               st_in.edge_count = 16'd0;
            end
         end else begin
            if (!st_in.switch_reg) begin
               st_in.edge_count = 16'd0;
               st_in.window_countdown = cfg_ff.heartbeat_window;
               st_in.sample_countdown = cfg_ff.heartbeat_sample;
            end
            st_in.window_countdown = st_in.window_countdown - 22'd1;
            st_in.sample_countdown = st_in.sample_countdown - 6'd1;
            if (st_in.sample_countdown == 6'd0) begin
               st_in.heartbeat_prev = st_in.heartbeat_cur;
               st_in.heartbeat_cur = req_heartbeat_in;
               st_in.sample_countdown = cfg_ff.heartbeat_sample;
               if (!st_in.heartbeat_prev && st_in.heartbeat_cur
                   && (st_in.edge_count != EdgeCountMax)) begin
                  st_in.edge_count = st_in.edge_count + 16'd1;
               end
            end
            if (st_in.window_countdown == 22'd0) begin
               st_in.window_countdown = cfg_ff.heartbeat_window;
               if (st_in.edge_count > cfg_ff.heartbeat_min_edges) begin
                  st_in.edge_count = 16'd0;
                  st_in.switch_reg = 1'b1;
               end else begin
                  st_in.switch_reg = 1'b0;
                  st_in.hold_countdown = cfg_ff.restart_hold;
                  if (cfg_ff.restart_hold == 20'd0) begin
                     if (st_in.led_reg) begin
                        st_in.switch_reg = 1'b1;
                     end
                     st_in.edge_count = 16'd0;
                  end
               end
            end

            if (req_supply_sample > cfg_ff.adc_threshold) begin
               if (req_ignition_in) begin
                  st_in.on_countdown = cfg_ff.on_delay;
                  if (st_in.off_countdown < cfg_ff.led_off_point) begin
                     st_in.led_reg = 1'b0;
                  end
                  if (st_in.off_countdown == 23'd0) begin
                     st_in.supply_timeout = cfg_ff.on_delay;
                     st_in.switch_reg = 1'b0;
                  end else begin
                     st_in.off_countdown = st_in.off_countdown - 23'd1;
                  end
               end else begin
                  st_in.off_countdown = cfg_ff.off_delay;
                  if (st_in.on_countdown == 16'd0) begin
                     st_in.led_reg = 1'b1;
                     st_in.switch_reg = 1'b1;
                  end else begin
                     st_in.on_countdown = st_in.on_countdown - 16'd1;
                  end
               end
            end else begin
               st_in.supply_timeout = st_in.supply_timeout - 16'd1;
            end
            if (st_in.supply_timeout == 16'd0) begin
               st_in.led_reg = 1'b0;
               st_in.switch_reg = 1'b0;
               st_in.phase_active = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ConfigReset;
         st_ff <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_switch_ff <= st_in.switch_reg;
         rsp_led_ff <= st_in.led_reg;
         rsp_active_ff <= st_in.phase_active;
         rsp_holding_ff <= (st_in.hold_countdown != 20'd0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_switch_on = rsp_switch_ff;
   assign rsp_led_on = rsp_led_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_holding = rsp_holding_ff;

   `IPTHB_ASSERT_NOW(a_stall_needs_word, clock, reset, !rsp_valid_ff, !req_stall)
   `IPTHB_ASSERT_NEXT(a_accept_gives_word, clock, reset, req_accept, rsp_valid_ff)
   `IPTHB_ASSERT_NEXT(a_state_holds_idle, clock, reset, !reset && !req_accept, $stable(st_ff))

endmodule

FILE: tb/sv/tb_ignition_power_timer_with_heartbeat.sv
// Self-checking testbench for the ignition power timer with heartbeat watchdog.
`timescale 1ns / 1ps

module tb_ignition_power_timer_with_heartbeat;
   import ipthb_pkg::*;

   localparam int QuietLimit = 3000;

   typedef struct packed {
      logic switch_on;
      logic led_on;
      logic active;
      logic holding;
   } tick_out_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_ignition_in;
   logic [7:0]               req_supply_sample;
   logic                     req_heartbeat_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_switch_on;
   logic                     rsp_led_on;
   logic                     rsp_active;
   logic                     rsp_holding;
   logic                     csr_write_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   config_type   timer_cfg;
   state_type    timer_st;
   tick_out_type expected_ticks[$];

   int words_sent;
   int results_checked;
   int mismatches;
   int settings_applied;
   int quiet_cycles;
   bit req_gaps_on;
   bit rsp_stalls_on;

   ignition_power_timer_with_heartbeat DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ignition_in  (req_ignition_in),
      .req_supply_sample(req_supply_sample),
      .req_heartbeat_in (req_heartbeat_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_switch_on    (rsp_switch_on),
      .rsp_led_on       (rsp_led_on),
      .rsp_active       (rsp_active),
      .rsp_holding      (rsp_holding),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic release_hold();
      if (timer_st.led_reg) begin
         timer_st.switch_reg = 1'b1;
      end
      timer_st.edge_count = '0;
   endtask

   task automatic advance_timer(input logic ign, input logic [7:0] level, input logic hb,
                                output tick_out_type outcome);
      if (!timer_st.phase_active) begin
         if (level < timer_cfg.adc_threshold || ign) begin
            timer_st.switch_reg = 1'b0;
         end else if (timer_cfg.on_delay == 0) begin
            timer_st.switch_reg = 1'b0;
            timer_st.led_reg = 1'b0;
         end else begin
            timer_st.on_countdown = timer_cfg.on_delay;
            timer_st.off_countdown = timer_cfg.off_delay;
            timer_st.supply_timeout = timer_cfg.on_delay;
            timer_st.phase_active = 1'b1;
         end
      end else if (timer_st.hold_countdown != 0) begin
         timer_st.hold_countdown = timer_st.hold_countdown - 20'd1;
         if (timer_st.hold_countdown == 0) begin
            release_hold();
         end
      end else begin
         if (!timer_st.switch_reg) begin
            timer_st.edge_count = '0;
            timer_st.window_countdown = timer_cfg.heartbeat_window;
            timer_st.sample_countdown = timer_cfg.heartbeat_sample;
         end
         timer_st.window_countdown = timer_st.window_countdown - 22'd1;
         timer_st.sample_countdown = timer_st.sample_countdown - 6'd1;
         if (timer_st.sample_countdown == 0) begin
            timer_st.heartbeat_prev = timer_st.heartbeat_cur;
            timer_st.heartbeat_cur = hb;
            timer_st.sample_countdown = timer_cfg.heartbeat_sample;
            if (!timer_st.heartbeat_prev && timer_st.heartbeat_cur &&
                timer_st.edge_count != EdgeCountMax) begin
               timer_st.edge_count = timer_st.edge_count + 16'd1;
            end
         end
         if (timer_st.window_countdown == 0) begin
            timer_st.window_countdown = timer_cfg.heartbeat_window;
            if (timer_st.edge_count > timer_cfg.heartbeat_min_edges) begin
               timer_st.edge_count = '0;
               timer_st.switch_reg = 1'b1;
            end else begin
               timer_st.switch_reg = 1'b0;
               timer_st.hold_countdown = timer_cfg.restart_hold;
               if (timer_st.hold_countdown == 0) begin
                  release_hold();
               end
            end
         end
         if (level > timer_cfg.adc_threshold) begin
            if (ign) begin
               timer_st.on_countdown = timer_cfg.on_delay;
               if (timer_st.off_countdown < timer_cfg.led_off_point) begin
                  timer_st.led_reg = 1'b0;
               end
               if (timer_st.off_countdown == 0) begin
                  timer_st.supply_timeout = timer_cfg.on_delay;
                  timer_st.switch_reg = 1'b0;
               end else begin
                  timer_st.off_countdown = timer_st.off_countdown - 23'd1;
               end
            end else begin
               timer_st.off_countdown = timer_cfg.off_delay;
               if (timer_st.on_countdown == 0) begin
                  timer_st.led_reg = 1'b1;
                  timer_st.switch_reg = 1'b1;
               end else begin
                  timer_st.on_countdown = timer_st.on_countdown - 16'd1;
               end
            end
         end else begin
            timer_st.supply_timeout = timer_st.supply_timeout - 16'd1;
         end
         if (timer_st.supply_timeout == 0) begin
            timer_st.led_reg = 1'b0;
            timer_st.switch_reg = 1'b0;
            timer_st.phase_active = 1'b0;
         end
      end
      outcome.switch_on = timer_st.switch_reg;
      outcome.led_on = timer_st.led_reg;
      outcome.active = timer_st.phase_active;
      outcome.holding = (timer_st.hold_countdown != 0);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input logic ign, input logic [7:0] level, input logic hb);
      int gap;
      tick_out_type outcome;
      gap = req_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ignition_in <= ign;
      req_supply_sample <= level;
      req_heartbeat_in <= hb;
      forever begin
         @(posedge clock);
         if (req_stall === 1'b0) begin
            break;
         end
      end
      advance_timer(ign, level, hb, outcome);
      expected_ticks.push_back(outcome);
      words_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_ADC_THRESHOLD: timer_cfg.adc_threshold = value[7:0];
         CSR_ON_DELAY:      timer_cfg.on_delay = value[15:0];
         CSR_OFF_DELAY:     timer_cfg.off_delay = value[22:0];
         CSR_LED_OFF_POINT: timer_cfg.led_off_point = value[22:0];
         CSR_HB_WINDOW:     timer_cfg.heartbeat_window = value[21:0];
         CSR_HB_SAMPLE:     timer_cfg.heartbeat_sample = value[5:0];
         CSR_HB_MIN_EDGES:  timer_cfg.heartbeat_min_edges = value[15:0];
         CSR_RESTART_HOLD:  timer_cfg.restart_hold = value[19:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic apply_setting(input logic [7:0] thr, input logic [15:0] on_ticks,
                                input logic [22:0] off_ticks, input logic [22:0] led_point,
                                input logic [21:0] window, input logic [5:0] sample_every,
                                input logic [15:0] min_edges, input logic [19:0] hold_ticks);
      drain_results();
      write_reg(CSR_ADC_THRESHOLD, CsrDataWidth'(thr));
      write_reg(CSR_ON_DELAY, CsrDataWidth'(on_ticks));
      write_reg(CSR_OFF_DELAY, off_ticks);
      write_reg(CSR_LED_OFF_POINT, led_point);
      write_reg(CSR_HB_WINDOW, CsrDataWidth'(window));
      write_reg(CSR_HB_SAMPLE, CsrDataWidth'(sample_every));
      write_reg(CSR_HB_MIN_EDGES, CsrDataWidth'(min_edges));
      write_reg(CSR_RESTART_HOLD, CsrDataWidth'(hold_ticks));
      settings_applied++;
   endtask

   task automatic run_random_words(input int count);
      logic ign;
      logic hb;
      logic [7:0] level;
      int hb_pct;
      int ign_odds;
      ign = 1'b0;
      hb = 1'b0;
      hb_pct = 50;
      ign_odds = $urandom_range(4, 30);
      req_gaps_on = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < count; i++) begin
         if (i % 30 == 0) begin
            case ($urandom_range(0, 3))
               0: hb_pct = 0;
               1: hb_pct = 25;
               2: hb_pct = 60;
               default: hb_pct = 100;
            endcase
         end
         if ($urandom_range(0, ign_odds) == 0) begin
            ign = ~ign;
         end
         if ($urandom_range(0, 99) < hb_pct) begin
            hb = ~hb;
         end
         if ($urandom_range(0, 99) < 85) begin
            level = (timer_cfg.adc_threshold == 8'hFF) ? 8'hFF :
                    8'($urandom_range(timer_cfg.adc_threshold + 1, 255));
         end else begin
            level = 8'($urandom_range(0, 255));
         end
         send_word(ign, level, hb);
      end
   endtask

   task automatic test_idle_gating();
      send_word(1'b1, 8'hFF, 1'b1);
      send_word(1'b0, 8'h00, 1'b0);
   endtask

   task automatic test_timing_and_watchdog();
      apply_setting(8'd100, 16'd3, 23'd2, 23'd1, 22'd8, 6'd1, 16'd1, 20'd2);
      send_word(1'b0, 8'd100, 1'b0);
      repeat (13) send_word(1'b0, 8'd200, 1'b0);
      send_word(1'b1, 8'd255, 1'b1);
      send_word(1'b1, 8'd255, 1'b0);
      send_word(1'b1, 8'd255, 1'b1);
      repeat (6) send_word(1'b1, 8'd100, 1'b0);
   endtask

   task automatic test_zero_on_delay();
      drain_results();
      write_reg(CSR_ON_DELAY, 23'd0);
      send_word(1'b0, 8'd200, 1'b0);
   endtask

   task automatic test_low_extremes();
      apply_setting(8'd0, 16'd1, 23'd1, 23'd0, 22'd1, 6'd1, 16'd0, 20'd0);
      run_random_words(60);
      apply_setting(8'($urandom_range(0, 150)), 16'd2, 23'd3, 23'd2, 22'd0, 6'd0, 16'd1,
                    20'd0);
      run_random_words(60);
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 12; p++) begin
         apply_setting(8'($urandom_range(0, 200)), 16'($urandom_range(1, 6)),
                       23'($urandom_range(1, 10)), 23'($urandom_range(0, 12)),
                       22'($urandom_range(2, 40)), 6'($urandom_range(1, 4)),
                       16'($urandom_range(0, 6)), 20'($urandom_range(0, 8)));
         run_random_words(80);
      end
   endtask

   task automatic test_high_extremes();
      apply_setting(8'hFF, 16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 22'h3FFFFF, 6'h3F, 16'hFFFF,
                    20'hFFFFF);
      run_random_words(40);
   endtask

   task automatic log_mismatch(input string detail);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at result %0d: %s", results_checked, detail);
      end
   endtask

   always @(posedge clock) begin : check_results
      tick_out_type seen;
      tick_out_type want;
      string field_name[4];
      field_name = '{"switch_on", "led_on", "active", "holding"};
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen = {rsp_switch_on, rsp_led_on, rsp_active, rsp_holding};
         if (expected_ticks.size() == 0) begin
            log_mismatch($sformatf("result %b with no word pending", seen));
         end else begin
            want = expected_ticks.pop_front();
            for (int b = 0; b < 4; b++) begin
               if (seen[3-b] !== want[3-b]) begin
                  log_mismatch($sformatf("%s expected %b got %b", field_name[b],
                                         want[3-b], seen[3-b]));
               end
            end
            results_checked++;
         end
      end
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap() + 1) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      while (quiet_cycles < QuietLimit) begin
         @(posedge clock);
      end
      $display("no handshake for %0d cycles", QuietLimit);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_ignition_in = 1'b0;
      req_supply_sample = '0;
      req_heartbeat_in = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      timer_cfg = ConfigReset;
      timer_st = '0;
      timer_st.window_countdown = ConfigReset.heartbeat_window;
      timer_st.sample_countdown = ConfigReset.heartbeat_sample;
      timer_st.edge_count = EdgeCountReset;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_gating();
      test_timing_and_watchdog();
      test_zero_on_delay();
      test_low_extremes();
      test_random_settings();
      test_high_extremes();

      drain_results();
      repeat (5) @(posedge clock);
      if (expected_ticks.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
      end
      $display("Sent %0d words under %0d register settings, checked %0d results.",
               words_sent, settings_applied, results_checked);
      $display("Mismatches found: %0d.", mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: ignition_power_timer_with_heartbeat.f
+incdir+rtl
rtl/ipthb_pkg.sv
rtl/ignition_power_timer_with_heartbeat.sv
tb/sv/tb_ignition_power_timer_with_heartbeat.sv
